### hw/rtl/ngve_pkg.sv
// Shared types, character codes and helper functions for the GGA/VTG field extractor.
package ngve_pkg;

    // Longest field kept; further characters are dropped and flagged
    localparam int MAX_FIELD_LEN = 16;
    localparam int CHAR_W        = $clog2(MAX_FIELD_LEN + 1);

    // Sentence classification
    typedef enum logic [1:0] {
        KIND_WAIT = 2'd0,
        KIND_GGA  = 2'd1,
        KIND_VTG  = 2'd2,
        KIND_REJ  = 2'd3
    } t_kind;

    // Field tags on the result channel
    typedef enum logic [2:0] {
        TAG_TIME  = 3'd0,
        TAG_LAT   = 3'd1,
        TAG_LON   = 3'd2,
        TAG_SATS  = 3'd3,
        TAG_ALT   = 3'd4,
        TAG_SPEED = 3'd5,
        TAG_NONE  = 3'd7
    } t_tag;

    localparam logic [2:0] HDR_LEN = 3'd6;
    localparam logic [2:0] HDR_SPLIT_POS = 3'd3;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_COMMA = 8'd44;

    localparam logic [3:0] COMMA_MAX = 4'd15;

    // Expected header byte: "$GPGGA" or "$GPVTG"
    function automatic logic [7:0] f_hdr_byte(input logic is_vtg, input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = "$";
            3'd1:    ch = "G";
            3'd2:    ch = "P";
            3'd3:    ch = is_vtg ? "V" : "G";
            3'd4:    ch = is_vtg ? "T" : "G";
            3'd5:    ch = is_vtg ? "G" : "A";
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

    // Which output field the current comma count selects
    function automatic t_tag f_route(input t_kind kind, input logic [3:0] commas);
        t_tag tag;
        tag = TAG_NONE;
        if (kind == KIND_GGA) begin
            case (commas)
                4'd1:    tag = TAG_TIME;
                4'd2:    tag = TAG_LAT;
                4'd4:    tag = TAG_LON;
                4'd7:    tag = TAG_SATS;
                4'd9:    tag = TAG_ALT;
                default: tag = TAG_NONE;
            endcase
        end else if (kind == KIND_VTG && commas == 4'd7) begin
            tag = TAG_SPEED;
        end
        return tag;
    endfunction

endpackage

### hw/rtl/nmea_gga_vtg_field_extractor.sv
// Top level: byte-wise NMEA GGA/VTG header match, comma counting and field routing.
// Path: a beat accepted into the input register passes the parse stage, and its result (if any)
//   is loaded into the output register once the output is not stalled.
// Throughput: one byte per cycle while the output is not stalled; the sentence state is updated once per byte in the
//   parse stage between the input register and the result register.
// Reset (synchronous, active low) clears both valid flags and all sentence state.
module nmea_gga_vtg_field_extractor
    import ngve_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_field_tag,
    output logic [3:0] o_char_pos,
    output logic [7:0] o_char_code,
    output logic       o_field_done,
    output logic [4:0] o_field_len,
    output logic       o_field_overflow
);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Sentence state
    logic [2:0]        r_hdr_pos,  n_hdr_pos;
    t_kind             r_kind,     n_kind;
    logic [3:0]        r_commas,   n_commas;
    logic [CHAR_W-1:0] r_chars,    n_chars;
    logic              r_ovf,      n_ovf;
    logic              r_stopped,  n_stopped;

    // Result register
    logic       r_out_valid;
    logic [2:0] r_tag;
    logic [3:0] r_pos;
    logic [7:0] r_code;
    logic       r_done;
    logic [4:0] r_len;
    logic       r_out_ovf;

    // Parse-stage result
    logic       w_res;
    logic [2:0] w_tag;
    logic [3:0] w_pos;
    logic [7:0] w_code;
    logic       w_done;
    logic [4:0] w_len;
    logic       w_ovf;

    logic       w_out_ready;
    logic       w_adv;
    logic [7:0] w_exp;
    t_tag       w_route;
    logic [CHAR_W+4:0] w_chars_ext;

    // Handshake
    assign w_out_ready = !r_out_valid || !i_stall;
    assign w_adv       = r_in_valid && w_out_ready;
    assign o_stall     = r_in_valid && !w_out_ready;

    assign w_exp       = f_hdr_byte(r_kind == KIND_VTG, r_hdr_pos);
    assign w_route     = f_route(r_kind, r_commas);
    assign w_chars_ext = {5'd0, r_chars};

    // Parse stage: next state and result for the byte in the input register
    always_comb begin
        n_hdr_pos = r_hdr_pos;
        n_kind    = r_kind;
        n_commas  = r_commas;
        n_chars   = r_chars;
        n_ovf     = r_ovf;
        n_stopped = r_stopped;
        w_res     = 1'b0;
        w_tag     = w_route;
        w_pos     = 4'd0;
        w_code    = 8'd0;
        w_done    = 1'b0;
        w_len     = 5'd0;
        w_ovf     = r_ovf;

        if (r_in_byte == CH_CR || r_in_byte == CH_LF) begin
            // line end: start a fresh sentence
            n_hdr_pos = 3'd0;
            n_kind    = KIND_WAIT;
            n_commas  = 4'd0;
            n_chars   = '0;
            n_ovf     = 1'b0;
            n_stopped = 1'b0;
        end else if (r_kind == KIND_REJ || r_stopped) begin
            // ignore until line end
        end else if (r_hdr_pos < HDR_LEN) begin
            // header match
            if (r_hdr_pos == HDR_SPLIT_POS) begin
                if (r_in_byte == f_hdr_byte(1'b0, r_hdr_pos)) begin
                    n_kind    = KIND_GGA;
                    n_hdr_pos = r_hdr_pos + 3'd1;
                end else if (r_in_byte == f_hdr_byte(1'b1, r_hdr_pos)) begin
                    n_kind    = KIND_VTG;
                    n_hdr_pos = r_hdr_pos + 3'd1;
                end else begin
                    n_kind = KIND_REJ;
                end
            end else if (r_in_byte == w_exp) begin
                n_hdr_pos = r_hdr_pos + 3'd1;
            end else begin
                n_kind = KIND_REJ;
            end
        end else if (r_in_byte inside {CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_NUL}) begin
            n_stopped = 1'b1;
        end else if (r_in_byte == CH_COMMA) begin
            // comma closes the field
            if (w_route != TAG_NONE) begin
                w_res  = 1'b1;
                w_done = 1'b1;
                w_len  = w_chars_ext[4:0];
            end
            if (r_commas != COMMA_MAX) begin
                n_commas = r_commas + 4'd1;
            end
            n_chars = '0;
            n_ovf   = 1'b0;
        end else if (w_route != TAG_NONE) begin
            // routed character, kept while there is room
            if (r_chars < CHAR_W'(MAX_FIELD_LEN)) begin
                w_res   = 1'b1;
                w_pos   = w_chars_ext[3:0];
                w_code  = r_in_byte;
                n_chars = r_chars + 1'b1;
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (!o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Sentence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pos <= 3'd0;
            r_kind    <= KIND_WAIT;
            r_commas  <= 4'd0;
            r_chars   <= '0;
            r_ovf     <= 1'b0;
            r_stopped <= 1'b0;
        end else if (w_adv) begin
            r_hdr_pos <= n_hdr_pos;
            r_kind    <= n_kind;
            r_commas  <= n_commas;
            r_chars   <= n_chars;
            r_ovf     <= n_ovf;
            r_stopped <= n_stopped;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_adv && w_res;
        end
        if (w_adv && w_res) begin
            r_tag     <= w_tag;
            r_pos     <= w_pos;
            r_code    <= w_code;
            r_done    <= w_done;
            r_len     <= w_len;
            r_out_ovf <= w_ovf;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_field_tag      = r_tag;
    assign o_char_pos       = r_pos;
    assign o_char_code      = r_code;
    assign o_field_done     = r_done;
    assign o_field_len      = r_len;
    assign o_field_overflow = r_out_ovf;

    // Checks
    a_tag_routed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_tag <= TAG_SPEED))
        else $error("result beat carries an unrouted tag");

    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_done) |-> (r_pos == 4'd0 && r_code == 8'd0))
        else $error("done beat carries character data");

    a_char_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_done) |-> (r_len == 5'd0 && !r_out_ovf))
        else $error("character beat carries length or overflow");

    a_hdr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_pos <= HDR_LEN)
        else $error("header position past header length");

    a_chars_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chars <= CHAR_W'(MAX_FIELD_LEN))
        else $error("field character count past limit");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_chars == CHAR_W'(MAX_FIELD_LEN)))
        else $error("overflow flagged on a field that is not full");

endmodule

### sim/tb_top.sv
// Self-checking testbench for the NMEA GGA/VTG field extractor.
`timescale 1ns / 100ps

module tb_top
    import ngve_pkg::*;
();

    localparam int WDOG_LIMIT   = 2000;
    localparam int LONG_HOLD    = 64;
    localparam int DRAIN_CYCLES = 8;
    localparam int RAND_BYTES   = 350;

    localparam logic [47:0] GGA_HDR = "$GPGGA";
    localparam logic [47:0] VTG_HDR = "$GPVTG";

    // One field result as the block reports it
    typedef struct packed {
        t_tag       tag;
        logic [3:0] pos;
        logic [7:0] code;
        logic       done;
        logic [4:0] len;
        logic       ovf;
    } t_fld_res;

    // Per-beat note: a hand-written expectation replaces the predicted one
    typedef struct packed {
        bit       typed;
        bit       has_res;
        t_fld_res res;
    } t_beat_note;

    // Directed stimulus row: up to eight characters, right-aligned, repeated
    typedef struct {
        logic [63:0] txt;
        int          nch;
        int          reps;
        bit          typed;
        bit          has_res;
        t_fld_res    res;
    } t_stim_row;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_rx_byte;
    logic       o_valid;
    logic       i_stall;
    logic [2:0] o_field_tag;
    logic [3:0] o_char_pos;
    logic [7:0] o_char_code;
    logic       o_field_done;
    logic [4:0] o_field_len;
    logic       o_field_overflow;

    nmea_gga_vtg_field_extractor uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_field_tag      (o_field_tag),
        .o_char_pos       (o_char_pos),
        .o_char_code      (o_char_code),
        .o_field_done     (o_field_done),
        .o_field_len      (o_field_len),
        .o_field_overflow (o_field_overflow)
    );

    // Sentence tracking state of the predictor
    logic [2:0] p_hdr_idx = '0;
    t_kind      p_kind    = KIND_WAIT;
    logic [3:0] p_commas  = '0;
    logic [4:0] p_chars   = '0;
    logic       p_ovf     = 1'b0;
    logic       p_stop    = 1'b0;

    t_fld_res   field_q[$];
    t_beat_note beat_note_q[$];
    t_stim_row  rows[$];

    int         err_cnt = 0;
    int         idle_cyc = 0;
    int         n_beats = 0;
    int         n_dir = 0;
    int         n_sentences = 0;
    int         n_res = 0;
    int         n_done = 0;
    int         n_ovf = 0;
    logic [7:0] tag_seen = '0;
    int         burst_left = 0;
    bit         hold_req = 1'b0;
    bit         hold_active = 1'b0;

    t_fld_res   mon_want;
    t_fld_res   mon_pred;
    t_beat_note mon_note;
    bit         mon_has;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Work out the field result that one received byte causes
    function automatic bit gps_predict(input logic [7:0] b, output t_fld_res r);
        t_tag       tag;
        logic [7:0] want;
        r = '0;
        if (b == CH_CR || b == CH_LF) begin
            p_hdr_idx = '0;
            p_kind    = KIND_WAIT;
            p_commas  = '0;
            p_chars   = '0;
            p_ovf     = 1'b0;
            p_stop    = 1'b0;
            return 1'b0;
        end
        if (p_kind == KIND_REJ || p_stop)
            return 1'b0;

        // header: first three bytes shared, fourth picks the sentence
        if (p_hdr_idx < HDR_LEN) begin
            if (p_hdr_idx == HDR_SPLIT_POS) begin
                if (b == "G")
                    p_kind = KIND_GGA;
                else if (b == "V")
                    p_kind = KIND_VTG;
                else begin
                    p_kind = KIND_REJ;
                    return 1'b0;
                end
            end else begin
                want = (p_kind == KIND_VTG) ? VTG_HDR[8*(5-p_hdr_idx) +: 8]
                                            : GGA_HDR[8*(5-p_hdr_idx) +: 8];
                if (b != want) begin
                    p_kind = KIND_REJ;
                    return 1'b0;
                end
            end
            p_hdr_idx++;
            return 1'b0;
        end

        if (b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF || b == CH_NUL) begin
            p_stop = 1'b1;
            return 1'b0;
        end

        // which output field the comma count selects
        tag = TAG_NONE;
        if (p_kind == KIND_GGA) begin
            case (p_commas)
                4'd1:    tag = TAG_TIME;
                4'd2:    tag = TAG_LAT;
                4'd4:    tag = TAG_LON;
                4'd7:    tag = TAG_SATS;
                4'd9:    tag = TAG_ALT;
                default: tag = TAG_NONE;
            endcase
        end else if (p_kind == KIND_VTG && p_commas == 4'd7) begin
            tag = TAG_SPEED;
        end

        if (b == CH_COMMA) begin
            if (tag != TAG_NONE) begin
                r.tag  = tag;
                r.done = 1'b1;
                r.len  = p_chars;
                r.ovf  = p_ovf;
            end
            if (p_commas != COMMA_MAX)
                p_commas++;
            p_chars = '0;
            p_ovf   = 1'b0;
            return tag != TAG_NONE;
        end

        if (tag == TAG_NONE)
            return 1'b0;
        if (p_chars < MAX_FIELD_LEN) begin
            r.tag  = tag;
            r.pos  = p_chars[3:0];
            r.code = b;
            r.ovf  = p_ovf;
            p_chars++;
            return 1'b1;
        end
        p_ovf = 1'b1;
        return 1'b0;
    endfunction

    function automatic void cmp_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    function automatic t_fld_res fr(t_tag tag, int pos, logic [7:0] code, bit done,
                                    int len, bit ovf);
        t_fld_res r;
        r.tag  = tag;
        r.pos  = pos[3:0];
        r.code = code;
        r.done = done;
        r.len  = len[4:0];
        r.ovf  = ovf;
        return r;
    endfunction

    function automatic t_stim_row seg(logic [63:0] txt, int nch, int reps);
        t_stim_row s;
        s.txt     = txt;
        s.nch     = nch;
        s.reps    = reps;
        s.typed   = 1'b0;
        s.has_res = 1'b0;
        s.res     = '0;
        return s;
    endfunction

    // Row whose last byte carries a hand-written expectation
    function automatic t_stim_row seg_t(logic [63:0] txt, int nch, int reps, bit has,
                                        t_fld_res res);
        t_stim_row s;
        s         = seg(txt, nch, reps);
        s.typed   = 1'b1;
        s.has_res = has;
        s.res     = res;
        return s;
    endfunction

    // Monitor: check results, predict accepted beats, watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (field_q.size() == 0) begin
                    $error("result with nothing pending: tag %0d pos %0d code 0x%02h done %0d",
                           o_field_tag, o_char_pos, o_char_code, o_field_done);
                    err_cnt++;
                end else begin
                    mon_want = field_q.pop_front();
                    cmp_field("field_tag", mon_want.tag, o_field_tag);
                    cmp_field("char_pos", mon_want.pos, o_char_pos);
                    cmp_field("char_code", mon_want.code, o_char_code);
                    cmp_field("field_done", mon_want.done, o_field_done);
                    cmp_field("field_len", mon_want.len, o_field_len);
                    cmp_field("field_overflow", mon_want.ovf, o_field_overflow);
                end
                n_res++;
                tag_seen[o_field_tag] = 1'b1;
                if (o_field_done)
                    n_done++;
                if (o_field_done && o_field_overflow)
                    n_ovf++;
            end

            if (i_valid && !o_stall) begin
                mon_note = beat_note_q.pop_front();
                mon_has  = gps_predict(i_rx_byte, mon_pred);
                if (mon_note.typed) begin
                    if (mon_note.has_res)
                        field_q.push_back(mon_note.res);
                end else if (mon_has) begin
                    field_q.push_back(mon_pred);
                end
            end

            if ((o_valid && !i_stall) || (i_valid && !o_stall)) begin
                idle_cyc = 0;
            end else begin
                idle_cyc++;
                if (idle_cyc >= WDOG_LIMIT) begin
                    $error("no beat moved for %0d cycles, %0d results pending",
                           idle_cyc, field_q.size());
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    // Receiver: stall pattern changes every so often; long hold on request
    initial begin
        t_rx_mode    rx_mode;
        int          stretch;
        int unsigned tick;
        i_stall = 1'b0;
        tick    = 0;
        forever begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            stretch = $urandom_range(20, 150);
            repeat (stretch) begin
                @(negedge i_clk);
                tick++;
                if (hold_req) begin
                    hold_req    = 1'b0;
                    hold_active = 1'b1;
                    i_stall     = 1'b1;
                    repeat (LONG_HOLD) @(negedge i_clk);
                    hold_active = 1'b0;
                end
                case (rx_mode)
                    RX_FREE:     i_stall = 1'b0;
                    RX_LIGHT:    i_stall = ($urandom_range(0, 3) == 0);
                    RX_HEAVY:    i_stall = ($urandom_range(0, 9) < 7);
                    RX_PERIODIC: i_stall = (tick % 3 == 0);
                    default:     i_stall = 1'b0;
                endcase
            end
        end
    end

    // Offer one byte and wait for it to be taken; bursts with gaps between
    task automatic send_beat(input logic [7:0] b, input t_beat_note note);
        if (burst_left <= 0) begin
            if (!(hold_req || hold_active)) begin
                i_valid = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 20);
        end
        burst_left--;
        beat_note_q.push_back(note);
        i_valid   = 1'b1;
        i_rx_byte = b;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        n_beats++;
    endtask

    // One random sentence: mostly well-formed GGA/VTG, some broken or noise
    task automatic send_sentence(input int unsigned pick);
        logic [7:0]  line[$];
        logic [47:0] hdr;
        logic [7:0]  c;
        int unsigned nfld;
        int unsigned flen;
        int unsigned r;
        if (pick < 90) begin
            hdr = (pick < 45) ? GGA_HDR : VTG_HDR;
            if (pick >= 80)
                hdr[8*$urandom_range(0, 5) +: 8] = 8'($urandom_range(0, 255));
            for (int i = 5; i >= 0; i--)
                line.push_back(hdr[8*i +: 8]);
            nfld = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 20) : $urandom_range(1, 11);
            repeat (nfld) begin
                line.push_back(CH_COMMA);
                r    = $urandom_range(0, 99);
                flen = (r < 80) ? $urandom_range(0, 6) :
                       (r < 95) ? $urandom_range(7, 15) : $urandom_range(16, 22);
                repeat (flen) begin
                    r = $urandom_range(0, 99);
                    if (r < 70)
                        c = 8'("0" + $urandom_range(0, 9));
                    else if (r < 97)
                        c = 8'($urandom_range(33, 126));
                    else
                        c = 8'($urandom_range(0, 255));
                    line.push_back(c);
                end
            end
        end else begin
            repeat ($urandom_range(3, 30))
                line.push_back(8'($urandom_range(0, 255)));
        end

        // line end: CR/LF pairs, single ends, checksum tail, or none
        r = $urandom_range(0, 99);
        if (r < 50) begin
            line.push_back(CH_CR);
            line.push_back(CH_LF);
        end else if (r < 65) begin
            line.push_back(CH_CR);
        end else if (r < 80) begin
            line.push_back(CH_LF);
        end else if (r < 92) begin
            line.push_back(CH_SPACE);
            line.push_back("*");
            line.push_back(8'($urandom_range(48, 57)));
            line.push_back(CH_CR);
            line.push_back(CH_LF);
        end
        foreach (line[k])
            send_beat(line[k], '0);
        n_sentences++;
    endtask

    // Stimulus and end of run
    initial begin
        t_stim_row  row;
        t_beat_note note;
        int         rand_start;
        bit         paused;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_rx_byte = '0;
        paused    = 1'b0;

        // GGA: time, over-long latitude, extreme longitude byte, stop on space
        rows.push_back(seg_t("$GPGGA,", 7, 1, 1'b0, '0));
        rows.push_back(seg_t("1", 1, 1, 1'b1, fr(TAG_TIME, 0, "1", 1'b0, 0, 1'b0)));
        rows.push_back(seg("23519", 5, 1));
        rows.push_back(seg_t(",", 1, 1, 1'b1, fr(TAG_TIME, 0, 8'd0, 1'b1, 6, 1'b0)));
        rows.push_back(seg_t("9", 1, 17, 1'b0, '0));
        rows.push_back(seg_t(",", 1, 1, 1'b1, fr(TAG_LAT, 0, 8'd0, 1'b1, 16, 1'b1)));
        rows.push_back(seg("N,", 2, 1));
        rows.push_back(seg_t(8'hFF, 1, 1, 1'b1, fr(TAG_LON, 0, 8'hFF, 1'b0, 0, 1'b0)));
        rows.push_back(seg_t(",", 1, 1, 1'b1, fr(TAG_LON, 0, 8'd0, 1'b1, 1, 1'b0)));
        rows.push_back(seg("W,1,", 4, 1));
        rows.push_back(seg("08,0.9,", 7, 1));
        rows.push_back(seg("545.4", 5, 1));
        rows.push_back(seg_t(CH_SPACE, 1, 1, 1'b0, '0));
        rows.push_back(seg_t(",M,", 3, 1, 1'b0, '0));
        rows.push_back(seg({CH_CR, CH_LF}, 2, 1));
        // header mismatch after a matching prefix
        rows.push_back(seg_t("$GPGSA,1", 8, 1, 1'b0, '0));
        rows.push_back(seg_t(",", 1, 1, 1'b0, '0));
        rows.push_back(seg(CH_LF, 1, 1));
        // VTG speed field, stopped by a tab
        rows.push_back(seg("$GPVTG,,", 8, 1));
        rows.push_back(seg(",,,,,", 5, 1));
        rows.push_back(seg_t("0", 1, 1, 1'b1, fr(TAG_SPEED, 0, "0", 1'b0, 0, 1'b0)));
        rows.push_back(seg("10.5", 4, 1));
        rows.push_back(seg_t(",", 1, 1, 1'b1, fr(TAG_SPEED, 0, 8'd0, 1'b1, 5, 1'b0)));
        rows.push_back(seg_t({"K", CH_TAB, ","}, 3, 1, 1'b0, '0));
        rows.push_back(seg(CH_CR, 1, 1));
        // comma count saturates rather than wrapping: no time field after it
        rows.push_back(seg("$GPGGA", 6, 1));
        rows.push_back(seg(",", 1, 20));
        rows.push_back(seg_t("7,", 2, 1, 1'b0, '0));
        rows.push_back(seg(CH_CR, 1, 1));
        // NUL ends the parse; line end inside an open field
        rows.push_back(seg("$GPGGA,", 7, 1));
        rows.push_back(seg_t({"4", CH_NUL, ","}, 3, 1, 1'b0, '0));
        rows.push_back(seg(CH_LF, 1, 1));
        rows.push_back(seg("$GPGGA,", 7, 1));
        rows.push_back(seg({"12", CH_CR}, 3, 1));
        rows.push_back(seg_t(",", 1, 1, 1'b0, '0));
        rows.push_back(seg(CH_LF, 1, 1));

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        foreach (rows[ri]) begin
            row = rows[ri];
            for (int k = 0; k < row.reps; k++) begin
                for (int c = 0; c < row.nch; c++) begin
                    note = '0;
                    if (row.typed && k == row.reps - 1 && c == row.nch - 1) begin
                        note.typed   = 1'b1;
                        note.has_res = row.has_res;
                        note.res     = row.res;
                    end
                    send_beat(row.txt[8*(row.nch-1-c) +: 8], note);
                end
            end
        end
        n_dir = n_beats;

        // random sentences; the first one runs against a long receiver hold
        rand_start = n_beats;
        hold_req   = 1'b1;
        send_sentence(0);
        while (n_beats - rand_start < RAND_BYTES) begin
            if (!paused && n_beats - rand_start > RAND_BYTES / 2) begin
                i_valid = 1'b0;
                while (field_q.size() != 0) @(negedge i_clk);
                paused = 1'b1;
            end
            send_sentence($urandom_range(0, 99));
        end
        i_valid = 1'b0;

        // drain, then allow for the pipeline
        while (field_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run: %0d bytes (%0d directed), %0d random sentences, %0d results checked",
                 n_beats, n_dir, n_sentences, n_res);
        $display("Fields closed: %0d, with overflow: %0d, tags seen (5..0): %b",
                 n_done, n_ovf, tag_seen[5:0]);
        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
hw/rtl/ngve_pkg.sv
hw/rtl/nmea_gga_vtg_field_extractor.sv
sim/tb_top.sv
